// ===== hdl/cbm_pkg.sv =====
// Shared types and constants of the codebook background model.
package cbm_pkg;

  localparam int PIX_BITS    = 12;
  localparam int NUM_PIXELS  = 1 << PIX_BITS;
  localparam int IDX_BITS    = 3;
  localparam int MAX_ENTRIES = 1 << IDX_BITS;
  localparam int CNT_BITS    = IDX_BITS + 1;
  localparam int TIME_BITS   = 16;
  localparam int NUM_CHAN    = 3;
  localparam int CW_ADDR_BITS = PIX_BITS + IDX_BITS;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam logic [CNT_BITS-1:0]  CNT_FULL = CNT_BITS'(MAX_ENTRIES);

  typedef enum logic [1:0] {
    CMD_LEARN  = 2'd0,
    CMD_DETECT = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_LEARN_BOUND = 3'd0,
    REG_MIN_LUMA    = 3'd1,
    REG_MIN_CR      = 3'd2,
    REG_MIN_CB      = 3'd3,
    REG_MAX_LUMA    = 3'd4,
    REG_MAX_CR      = 3'd5,
    REG_MAX_CB      = 3'd6,
    REG_UNUSED      = 3'd7
  } reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PXRD,
    ST_LOAD,
    ST_CWRD,
    ST_CWPROC,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [PIX_BITS-1:0] pixel_index;
    logic [7:0]          chan_luma;
    logic [7:0]          chan_cr;
    logic [7:0]          chan_cb;
  } in_item_t;

  typedef struct packed {
    logic                foreground;
    logic [CNT_BITS-1:0] entry_slot;
    logic                book_full;
    logic [CNT_BITS-1:0] entries_in_book;
    logic [CNT_BITS-1:0] entries_cleared;
  } out_item_t;

  // one codeword
  typedef struct packed {
    logic [NUM_CHAN-1:0][7:0] lrn_lo;
    logic [NUM_CHAN-1:0][7:0] lrn_hi;
    logic [NUM_CHAN-1:0][7:0] vmin;
    logic [NUM_CHAN-1:0][7:0] vmax;
    logic [TIME_BITS-1:0]     t_hit;
    logic [TIME_BITS-1:0]     stale;
  } cword_t;

  // per-pixel word
  typedef struct packed {
    logic [CNT_BITS-1:0]  cnt;
    logic [TIME_BITS-1:0] ptime;
  } pix_word_t;

  typedef struct packed {
    logic latch;
    logic pix_rd;
    logic load;
    logic cw_rd;
    logic cw_proc;
    logic finish;
    logic clr_step;
  } cbm_ctl_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
    logic clr_last;
  } cbm_sts_t;

endpackage

// ===== hdl/cbm_ctrl.sv =====
// Sequencer of the codebook background model.
module cbm_ctrl
  import cbm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  cbm_sts_t sts,
  output cbm_ctl_t ctl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = ST_PXRD;
      ST_PXRD:   state_nxt = ST_LOAD;
      ST_LOAD:   state_nxt = ST_CWRD;
      ST_CWRD:   state_nxt = sts.scan_done ? ST_FINISH : ST_CWPROC;
      ST_CWPROC: state_nxt = ST_CWRD;
      ST_FINISH: if (sts.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_CLEAR:  ctl.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready  = 1'b1;
        ctl.latch = in_valid;
      end
      ST_PXRD:   ctl.pix_rd = 1'b1;
      ST_LOAD:   ctl.load = 1'b1;
      ST_CWRD:   ctl.cw_rd = !sts.scan_done;
      ST_CWPROC: ctl.cw_proc = 1'b1;
      ST_FINISH: ctl.finish = sts.out_free;
      default:   ctl = '0;
    endcase
  end

endmodule

// ===== hdl/cbm_dpath.sv =====
// Datapath of the codebook background model: memories, config and codeword logic.
module cbm_dpath
  import cbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  logic       cfg_valid,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  cbm_ctl_t   ctl,
  output cbm_sts_t   sts
);

  // memories
  pix_word_t pix_mem [NUM_PIXELS];
  cword_t    cw_mem  [NUM_PIXELS*MAX_ENTRIES];

  // config registers
  logic [7:0]              lb_r;
  logic signed [NUM_CHAN-1:0][8:0] mlo_r, mhi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lb_r  <= 8'd10;
      mlo_r <= {9'sd35, 9'sd8, 9'sd8};
      mhi_r <= {9'sd25, 9'sd8, 9'sd8};
    end else if (cfg_valid) begin
      unique case (reg_t'(cfg_index))
        REG_LEARN_BOUND: lb_r     <= cfg_data[7:0];
        REG_MIN_LUMA:    mlo_r[2] <= cfg_data;
        REG_MIN_CR:      mlo_r[1] <= cfg_data;
        REG_MIN_CB:      mlo_r[0] <= cfg_data;
        REG_MAX_LUMA:    mhi_r[2] <= cfg_data;
        REG_MAX_CR:      mhi_r[1] <= cfg_data;
        REG_MAX_CB:      mhi_r[0] <= cfg_data;
        default:         lb_r     <= lb_r;
      endcase
    end
  end

  // item and scan registers
  in_item_t             item_r;
  pix_word_t            pix_rd_r;
  cword_t               cw_rd_r;
  logic [CNT_BITS-1:0]  cnt_r, idx_r, kept_r;
  logic [TIME_BITS-1:0] t_r, thr_r;
  logic [IDX_BITS-1:0]  slot_r;
  logic                 hit_r, cov_r;
  logic [PIX_BITS-1:0]  clr_idx_r;
  logic                 out_valid_r;
  out_item_t            out_r;

  logic [NUM_CHAN-1:0][7:0] smp, hi, lo;
  logic [8:0]               hsum [NUM_CHAN];
  logic [TIME_BITS-1:0]     tbase;

  assign smp = {item_r.chan_luma, item_r.chan_cr, item_r.chan_cb};

  // new learning box around the sample
  always_comb begin
    for (int n = 0; n < NUM_CHAN; n++) begin
      hsum[n] = {1'b0, smp[n]} + {1'b0, lb_r};
      hi[n]   = hsum[n][8] ? 8'hff : hsum[n][7:0];
      lo[n]   = (smp[n] > lb_r) ? smp[n] - lb_r : 8'd0;
    end
    tbase = (pix_rd_r.cnt == '0) ? '0 : pix_rd_r.ptime;
  end

  // per-codeword update
  logic                 lmatch, dcover, keep;
  logic [TIME_BITS-1:0] run;
  cword_t               cw_upd;
  logic signed [10:0]   dlo [NUM_CHAN];
  logic signed [10:0]   dhi [NUM_CHAN];
  logic signed [10:0]   sv  [NUM_CHAN];

  always_comb begin
    lmatch = !hit_r;
    dcover = 1'b1;
    for (int n = 0; n < NUM_CHAN; n++) begin
      if (!(cw_rd_r.lrn_lo[n] <= smp[n] && smp[n] <= cw_rd_r.lrn_hi[n])) lmatch = 1'b0;
      sv[n]  = $signed({3'b000, smp[n]});
      // slack registers are signed: sign-extend before widening
      dlo[n] = $signed({3'b000, cw_rd_r.vmin[n]}) - 11'($signed(mlo_r[n]));
      dhi[n] = $signed({3'b000, cw_rd_r.vmax[n]}) + 11'($signed(mhi_r[n]));
      if (!(dlo[n] <= sv[n] && sv[n] <= dhi[n])) dcover = 1'b0;
    end
    run    = (t_r >= cw_rd_r.t_hit) ? t_r - cw_rd_r.t_hit : '0;
    cw_upd = cw_rd_r;
    if (lmatch) begin
      cw_upd.t_hit = t_r;
      for (int n = 0; n < NUM_CHAN; n++) begin
        if (cw_rd_r.vmax[n] < smp[n])      cw_upd.vmax[n] = smp[n];
        else if (cw_rd_r.vmin[n] > smp[n]) cw_upd.vmin[n] = smp[n];
        if (cw_rd_r.lrn_hi[n] < hi[n]) cw_upd.lrn_hi[n] = cw_rd_r.lrn_hi[n] + 8'd1;
        if (cw_rd_r.lrn_lo[n] > lo[n]) cw_upd.lrn_lo[n] = cw_rd_r.lrn_lo[n] - 8'd1;
      end
    end else if (cw_rd_r.stale < run) begin
      cw_upd.stale = run;
    end
    keep = (cw_rd_r.stale <= thr_r);
  end

  // codeword write port
  logic                    cw_we;
  logic [CW_ADDR_BITS-1:0] cw_wa;
  cword_t                  cw_wd;
  logic                    learn_new;

  assign learn_new = !hit_r && (cnt_r != CNT_FULL);

  always_comb begin
    cw_we = 1'b0;
    cw_wa = {item_r.pixel_index, idx_r[IDX_BITS-1:0]};
    cw_wd = cw_upd;
    if (ctl.cw_proc) begin
      case (cmd_t'(item_r.cmd))
        CMD_LEARN: cw_we = 1'b1;
        CMD_CLEAR: begin
          cw_we       = keep;
          cw_wa       = {item_r.pixel_index, kept_r[IDX_BITS-1:0]};
          cw_wd       = cw_rd_r;
          cw_wd.t_hit = '0;
          cw_wd.stale = '0;
        end
        default: cw_we = 1'b0;
      endcase
    end else if (ctl.finish && cmd_t'(item_r.cmd) == CMD_LEARN && learn_new) begin
      cw_we        = 1'b1;
      cw_wa        = {item_r.pixel_index, cnt_r[IDX_BITS-1:0]};
      cw_wd.lrn_lo = lo;
      cw_wd.lrn_hi = hi;
      cw_wd.vmin   = smp;
      cw_wd.vmax   = smp;
      cw_wd.t_hit  = t_r;
      cw_wd.stale  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw_we) cw_mem[cw_wa] <= cw_wd;
    if (ctl.cw_rd) cw_rd_r <= cw_mem[{item_r.pixel_index, idx_r[IDX_BITS-1:0]}];
  end

  // pixel memory write port
  logic                pix_we;
  logic [PIX_BITS-1:0] pix_wa;
  pix_word_t           pix_wd;

  always_comb begin
    pix_we = 1'b0;
    pix_wa = item_r.pixel_index;
    pix_wd = '{cnt: cnt_r, ptime: t_r};
    if (ctl.clr_step) begin
      pix_we = 1'b1;
      pix_wa = clr_idx_r;
      pix_wd = '0;
    end else if (ctl.finish) begin
      case (cmd_t'(item_r.cmd))
        CMD_LEARN: begin
          pix_we = 1'b1;
          if (learn_new) pix_wd.cnt = cnt_r + 1'b1;
        end
        CMD_CLEAR: begin
          pix_we = 1'b1;
          pix_wd = '{cnt: kept_r, ptime: '0};
        end
        default: pix_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pix_we) pix_mem[pix_wa] <= pix_wd;
    if (ctl.pix_rd) pix_rd_r <= pix_mem[item_r.pixel_index];
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (ctl.latch) item_r <= in_data;
    if (ctl.load) begin
      cnt_r  <= pix_rd_r.cnt;
      thr_r  <= pix_rd_r.ptime >> 1;
      t_r    <= (tbase == TIME_MAX) ? tbase : tbase + 1'b1;
      idx_r  <= '0;
      kept_r <= '0;
      hit_r  <= 1'b0;
      cov_r  <= 1'b0;
      slot_r <= '0;
    end
    if (ctl.cw_proc) begin
      idx_r <= idx_r + 1'b1;
      if (lmatch) begin
        hit_r  <= 1'b1;
        slot_r <= idx_r[IDX_BITS-1:0];
      end
      if (dcover) cov_r <= 1'b1;
      if (keep) kept_r <= kept_r + 1'b1;
    end
  end

  // power-on clearing pass over the pixel memory
  always_ff @(posedge clk) begin
    if (!rst_n)            clr_idx_r <= '0;
    else if (ctl.clr_step) clr_idx_r <= clr_idx_r + 1'b1;
  end

  // result register
  out_item_t res;

  always_comb begin
    res = '0;
    res.entries_in_book = cnt_r;
    case (cmd_t'(item_r.cmd))
      CMD_LEARN: begin
        if (hit_r) begin
          res.entry_slot = {1'b0, slot_r};
        end else if (learn_new) begin
          res.entry_slot      = cnt_r;
          res.entries_in_book = cnt_r + 1'b1;
        end else begin
          res.entry_slot = CNT_FULL;
          res.book_full  = 1'b1;
        end
      end
      CMD_DETECT: res.foreground = !cov_r;
      CMD_CLEAR: begin
        res.entries_in_book = kept_r;
        res.entries_cleared = cnt_r - kept_r;
      end
      default: res.entries_in_book = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n)          out_valid_r <= 1'b0;
    else if (ctl.finish) out_valid_r <= 1'b1;
    else if (out_ready)  out_valid_r <= 1'b0;
    if (ctl.finish) out_r <= res;
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_r;
  assign sts.scan_done = (idx_r == cnt_r);
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.clr_last  = &clr_idx_r;

endmodule

// ===== hdl/codebook_background_model.sv =====
// Top level of the per-pixel codebook background model.
// After reset the block zeroes its per-pixel count and time words, one pixel at
// a time, and takes no beat meanwhile (configuration writes are taken). Each item
// then makes one pass over the pixel's codewords, of which there are at most 8:
// after a pixel-word read and setup it reads them one at a time through the
// single-port codeword memory, writing each back on learn and each kept one on
// clear, then writes the pixel word back on learn and clear. A result beat waits
// in an output register, so the next item is worked on while it is not yet taken.
module codebook_background_model
  import cbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_data
);

  cbm_ctl_t ctl;
  cbm_sts_t sts;

  assign cfg_ready = 1'b1;

  cbm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  cbm_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule
